// ===== rtl/websocket_frame_deframer_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Needs signals named clk and arst_n in the scope where a macro is used.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define WSD_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("deframer check failed");

// A condition that, once seen, implies another at the next clock edge.
`define WSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer sequence check failed");

`endif

// ===== rtl/wsd_pkg.sv =====
// Types and constants of the WebSocket frame deframer.
// Used by every RTL module of the block; depends on nothing.
package wsd_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       buf_start;
	} rx_item_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [3:0]  opcode;
		logic        fin;
		logic        masked;
		logic [15:0] frame_size;
		logic [7:0]  payload_byte;
		logic        last;
	} ev_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_KEY  = 3'd3,
		PH_DATA = 3'd4,
		PH_DROP = 3'd5
	} phase_t;

	localparam logic [1:0] EV_PAYLOAD = 2'd0;
	localparam logic [1:0] EV_HEADER  = 2'd1;
	localparam logic [1:0] EV_INVALID = 2'd2;

	localparam logic [3:0] OPCODE_MAX  = 4'hA;
	localparam logic [6:0] LEN_CODE16  = 7'd126;
	localparam logic [6:0] LEN_CODE64  = 7'd127;
	localparam logic [1:0] EXT_LAST    = 2'd1;
	localparam logic [1:0] KEY_LAST    = 2'd3;

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
// WebSocket frame deframer, receive side, 7-bit and 16-bit payload lengths.
// Channel rx carries one stream byte per item with a flag for the first byte
// of each received buffer; channel ev carries header, invalid-header and
// unmasked payload items. Both use valid and stall: an item moves on a rising
// edge where valid is high and stall is low.
// The result of an accepted byte is written into the queue, then moved into the
// output register that presents it on ev. The parser takes one byte every cycle
// while the queue is not full; bytes that produce no result (most header bytes,
// dropped bytes) leave the queue untouched. The front parser and the output
// register are parted by a queue of QUEUE_DEPTH items, so one byte per cycle is
// sustained while ev is not stalled; rx stalls only once the queue is full.
// Reset clears the parser to expect the first header byte and empties the
// queue and output register; nothing needs to be written before use.
// While ev is stalled the presented item holds, the queue fills, and rx stall
// rises when it is full.
// Depends on wsd_pkg, wsd_front, wsd_queue, wsd_back and the macro header.
`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_stall,
	input  wsd_pkg::rx_item_t rx_item,
	output logic              ev_valid,
	input  logic              ev_stall,
	output wsd_pkg::ev_item_t ev_item
);

	logic              push;
	logic              pop;
	wsd_pkg::ev_item_t push_item;
	wsd_pkg::ev_item_t head_item;
	wsd_pkg::q_stat_t  q_stat;

	wsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_item   (rx_item),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	wsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_stat    (q_stat)
	);

	wsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head_item (head_item),
		.pop       (pop),
		.ev_valid  (ev_valid),
		.ev_stall  (ev_stall),
		.ev_item   (ev_item)
	);

	`WSD_ASSERT_ALWAYS(a_q_stat_sane, !(q_stat.full && q_stat.empty))
	`WSD_ASSERT_ALWAYS(a_no_push_full, !(push && q_stat.full))
	`WSD_ASSERT_ALWAYS(a_no_pop_empty, !(pop && q_stat.empty))
	`WSD_ASSERT_NEXT(a_pop_fills_out, pop, ev_valid)

endmodule

// ===== rtl/wsd_front.sv =====
// Front end of the deframer: takes received bytes, runs the header parser
// and pushes each resulting item into the queue. Uses wsd_pkg.
module wsd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_stall,
	input  wsd_pkg::rx_item_t rx_item,
	input  wsd_pkg::q_stat_t  q_stat,
	output logic              push,
	output wsd_pkg::ev_item_t push_item
);

	wsd_pkg::phase_t phase_q, phase_d, ph_eff;
	logic [3:0]  op_q;
	logic        fin_q;
	logic        mask_q;
	logic [15:0] len_q;
	logic [15:0] left_q;
	logic [1:0]  cnt_q;
	logic [31:0] key_q;
	logic [1:0]  kpos_q;

	logic        acc;
	logic        abort;
	logic        restart;
	logic [7:0]  b;
	logic [6:0]  code;
	logic        hdr1_bad;
	logic [15:0] len_hdr1;
	logic [15:0] ext_len;
	logic [7:0]  key_byte;
	logic        res_valid;
	wsd_pkg::ev_item_t res;

	assign rx_stall = q_stat.full;
	assign acc      = rx_valid && !q_stat.full;
	assign b        = rx_item.in_byte;
	assign code     = b[6:0];

	// A buffer start inside a header reports the header as broken; a buffer
	// start in the header or drop phases restarts the parse on this byte.
	assign abort   = rx_item.buf_start && (phase_q == wsd_pkg::PH_HDR1 ||
		phase_q == wsd_pkg::PH_EXT || phase_q == wsd_pkg::PH_KEY);
	assign restart = abort || (rx_item.buf_start && phase_q == wsd_pkg::PH_DROP);
	assign ph_eff  = restart ? wsd_pkg::PH_HDR0 : phase_q;

	assign hdr1_bad = (op_q > wsd_pkg::OPCODE_MAX) || (code == wsd_pkg::LEN_CODE64);
	assign len_hdr1 = {9'd0, code};
	assign ext_len  = {len_q[7:0], b};
	// Key bytes are used most significant first.
	assign key_byte = key_q[{~kpos_q, 3'b000} +: 8];

	always_comb begin
		phase_d = ph_eff;
		case (ph_eff)
			wsd_pkg::PH_HDR0: phase_d = wsd_pkg::PH_HDR1;
			wsd_pkg::PH_HDR1: begin
				if (hdr1_bad)
					phase_d = wsd_pkg::PH_DROP;
				else if (code == wsd_pkg::LEN_CODE16)
					phase_d = wsd_pkg::PH_EXT;
				else if (b[7])
					phase_d = wsd_pkg::PH_KEY;
				else if (len_hdr1 == 16'd0)
					phase_d = wsd_pkg::PH_HDR0;
				else
					phase_d = wsd_pkg::PH_DATA;
			end
			wsd_pkg::PH_EXT: begin
				if (cnt_q == wsd_pkg::EXT_LAST) begin
					if (mask_q)
						phase_d = wsd_pkg::PH_KEY;
					else if (ext_len == 16'd0)
						phase_d = wsd_pkg::PH_HDR0;
					else
						phase_d = wsd_pkg::PH_DATA;
				end
			end
			wsd_pkg::PH_KEY: begin
				if (cnt_q == wsd_pkg::KEY_LAST)
					phase_d = (len_q == 16'd0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_DATA;
			end
			wsd_pkg::PH_DATA: begin
				if (left_q == 16'd1)
					phase_d = wsd_pkg::PH_HDR0;
			end
			wsd_pkg::PH_DROP: phase_d = wsd_pkg::PH_DROP;
			default: phase_d = wsd_pkg::PH_HDR0;
		endcase
	end

	always_comb begin
		res_valid        = 1'b0;
		res              = '0;
		res.opcode       = op_q;
		res.fin          = fin_q;
		res.masked       = mask_q;
		if (abort) begin
			res_valid     = 1'b1;
			res.event_res = wsd_pkg::EV_INVALID;
		end else begin
			case (ph_eff)
				wsd_pkg::PH_HDR1: begin
					res.masked = b[7];
					if (hdr1_bad) begin
						res_valid     = 1'b1;
						res.event_res = wsd_pkg::EV_INVALID;
					end else if (code != wsd_pkg::LEN_CODE16 && !b[7]) begin
						res_valid      = 1'b1;
						res.event_res  = wsd_pkg::EV_HEADER;
						res.frame_size = len_hdr1;
						res.last       = (len_hdr1 == 16'd0);
					end
				end
				wsd_pkg::PH_EXT: begin
					if (cnt_q == wsd_pkg::EXT_LAST && !mask_q) begin
						res_valid      = 1'b1;
						res.event_res  = wsd_pkg::EV_HEADER;
						res.frame_size = ext_len;
						res.last       = (ext_len == 16'd0);
					end
				end
				wsd_pkg::PH_KEY: begin
					if (cnt_q == wsd_pkg::KEY_LAST) begin
						res_valid      = 1'b1;
						res.event_res  = wsd_pkg::EV_HEADER;
						res.frame_size = len_q;
						res.last       = (len_q == 16'd0);
					end
				end
				wsd_pkg::PH_DATA: begin
					res_valid        = 1'b1;
					res.event_res    = wsd_pkg::EV_PAYLOAD;
					res.frame_size   = len_q;
					res.payload_byte = b ^ key_byte;
					res.last         = (left_q == 16'd1);
				end
				default: res_valid = 1'b0;
			endcase
		end
	end

	assign push      = acc && res_valid;
	assign push_item = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsd_pkg::PH_HDR0;
			op_q    <= '0;
			fin_q   <= 1'b0;
			mask_q  <= 1'b0;
			len_q   <= '0;
			left_q  <= '0;
			cnt_q   <= '0;
			key_q   <= '0;
			kpos_q  <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			case (ph_eff)
				wsd_pkg::PH_HDR0: begin
					fin_q  <= b[7];
					op_q   <= b[3:0];
					mask_q <= 1'b0;
					len_q  <= '0;
					left_q <= '0;
					cnt_q  <= '0;
					key_q  <= '0;
					kpos_q <= '0;
				end
				wsd_pkg::PH_HDR1: begin
					mask_q <= b[7];
					if (!hdr1_bad) begin
						cnt_q <= '0;
						if (code != wsd_pkg::LEN_CODE16) begin
							len_q  <= len_hdr1;
							left_q <= len_hdr1;
							kpos_q <= '0;
						end
					end
				end
				wsd_pkg::PH_EXT: begin
					len_q <= ext_len;
					if (cnt_q == wsd_pkg::EXT_LAST) begin
						cnt_q  <= '0;
						left_q <= ext_len;
						kpos_q <= '0;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				wsd_pkg::PH_KEY: begin
					key_q <= {key_q[23:0], b};
					if (cnt_q == wsd_pkg::KEY_LAST) begin
						cnt_q  <= '0;
						left_q <= len_q;
						kpos_q <= '0;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				wsd_pkg::PH_DATA: begin
					kpos_q <= kpos_q + 2'd1;
					left_q <= left_q - 16'd1;
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/wsd_queue.sv =====
// Short item queue between the parser front end and the output stage.
// Uses wsd_pkg for the item type and the status struct.
module wsd_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wsd_pkg::ev_item_t push_item,
	input  logic              pop,
	output wsd_pkg::ev_item_t head_item,
	output wsd_pkg::q_stat_t  q_stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	wsd_pkg::ev_item_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign head_item    = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

// ===== rtl/wsd_back.sv =====
// Output stage of the deframer: moves queued items into the output register
// and presents them to the receiver. Uses wsd_pkg.
module wsd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  wsd_pkg::q_stat_t  q_stat,
	input  wsd_pkg::ev_item_t head_item,
	output logic              pop,
	output logic              ev_valid,
	input  logic              ev_stall,
	output wsd_pkg::ev_item_t ev_item
);

	logic              valid_q;
	wsd_pkg::ev_item_t item_q;

	// The register reloads whenever it is empty or its item is being taken.
	assign pop      = !q_stat.empty && (!valid_q || !ev_stall);
	assign ev_valid = valid_q;
	assign ev_item  = item_q;

	always_ff @(posedge clk) begin
		if (pop)
			item_q <= head_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !ev_stall) begin
			valid_q <= !q_stat.empty;
		end
	end

endmodule

// ===== sim/websocket_frame_deframer_tb.sv =====
// Self-checking testbench for websocket_frame_deframer: a directed table, then random frames.
// Results are predicted by an in-bench model of the parser and compared field by field.
// Depends on wsd_pkg and the deframer RTL only.
module websocket_frame_deframer_tb;

	typedef enum logic [1:0] {
		ROW_PREDICT = 2'd0,
		ROW_SILENT  = 2'd1,
		ROW_TYPED   = 2'd2
	} row_kind_t;

	typedef struct packed {
		logic [7:0]        b;
		logic              bs;
		row_kind_t         kind;
		wsd_pkg::ev_item_t res;
	} stim_row_t;

	localparam wsd_pkg::ev_item_t NO_EV = '0;
	localparam int DIR_ROWS = 25;

	// Obvious results are written in; silent rows expect none; the rest use the predictor.
	localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
		'{8'h81, 1'b1, ROW_SILENT, NO_EV},
		'{8'h00, 1'b0, ROW_TYPED,
			'{wsd_pkg::EV_HEADER, 4'h1, 1'b1, 1'b0, 16'h0000, 8'h00, 1'b1}},
		'{8'h8B, 1'b0, ROW_SILENT, NO_EV},
		'{8'h80, 1'b0, ROW_TYPED,
			'{wsd_pkg::EV_INVALID, 4'hB, 1'b1, 1'b1, 16'h0000, 8'h00, 1'b0}},
		'{8'hFF, 1'b0, ROW_SILENT, NO_EV},
		'{8'h0A, 1'b1, ROW_SILENT, NO_EV},
		'{8'hFF, 1'b0, ROW_TYPED,
			'{wsd_pkg::EV_INVALID, 4'hA, 1'b0, 1'b1, 16'h0000, 8'h00, 1'b0}},
		'{8'h02, 1'b1, ROW_SILENT, NO_EV},
		'{8'hFE, 1'b0, ROW_SILENT, NO_EV},
		'{8'h00, 1'b0, ROW_SILENT, NO_EV},
		'{8'h03, 1'b0, ROW_SILENT, NO_EV},
		'{8'hFF, 1'b0, ROW_SILENT, NO_EV},
		'{8'h00, 1'b0, ROW_SILENT, NO_EV},
		'{8'hA5, 1'b0, ROW_SILENT, NO_EV},
		'{8'h5A, 1'b0, ROW_PREDICT, NO_EV},
		'{8'h00, 1'b0, ROW_PREDICT, NO_EV},
		'{8'hFF, 1'b0, ROW_PREDICT, NO_EV},
		'{8'h12, 1'b0, ROW_PREDICT, NO_EV},
		'{8'h88, 1'b1, ROW_SILENT, NO_EV},
		'{8'h7E, 1'b0, ROW_SILENT, NO_EV},
		'{8'hFF, 1'b0, ROW_SILENT, NO_EV},
		'{8'h01, 1'b1, ROW_TYPED,
			'{wsd_pkg::EV_INVALID, 4'h8, 1'b1, 1'b0, 16'h0000, 8'h00, 1'b0}},
		'{8'h7E, 1'b0, ROW_SILENT, NO_EV},
		'{8'h00, 1'b0, ROW_SILENT, NO_EV},
		'{8'h00, 1'b0, ROW_TYPED,
			'{wsd_pkg::EV_HEADER, 4'h1, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b1}}
	};

	logic              clk;
	logic              arst_n;
	logic              rx_valid;
	logic              rx_stall;
	wsd_pkg::rx_item_t rx_item;
	logic              ev_valid;
	logic              ev_stall;
	wsd_pkg::ev_item_t ev_item;

	row_kind_t         row_kind;
	wsd_pkg::ev_item_t row_typed;

	wsd_pkg::ev_item_t pending_events [$];
	int        err_count = 0;
	int        bytes_sent;
	int        burst_left;
	int        nogap_left;
	int        hold_req;
	int        holds_done = 0;
	int        n_headers = 0;
	int        n_payload = 0;
	int        n_invalid = 0;
	bit        resync;

	// Parser state mirrored by the predictor.
	wsd_pkg::phase_t ph = wsd_pkg::PH_HDR0;
	logic [3:0]  cur_op = 4'h0;
	logic        cur_fin = 1'b0;
	logic        cur_masked = 1'b0;
	logic [15:0] plen = 16'd0;
	logic [15:0] remaining = 16'd0;
	logic [1:0]  hdr_cnt = 2'd0;
	logic [31:0] key = 32'd0;
	logic [1:0]  key_idx = 2'd0;

	websocket_frame_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_item  (rx_item),
		.ev_valid (ev_valid),
		.ev_stall (ev_stall),
		.ev_item  (ev_item)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 400000);
		$display("Timeout: results still outstanding: %0d", pending_events.size());
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= 100)
			$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	function automatic wsd_pkg::ev_item_t make_ev(input logic [1:0] ev,
			input logic [15:0] size, input logic [7:0] pb, input logic lst);
		wsd_pkg::ev_item_t r;
		r.event_res    = ev;
		r.opcode       = cur_op;
		r.fin          = cur_fin;
		r.masked       = cur_masked;
		r.frame_size   = size;
		r.payload_byte = pb;
		r.last         = lst;
		return r;
	endfunction

	task automatic header_done(output bit got, output wsd_pkg::ev_item_t res);
		res = make_ev(wsd_pkg::EV_HEADER, plen, 8'h00, plen == 16'd0);
		got = 1'b1;
		key_idx = 2'd0;
		if (plen == 16'd0) begin
			ph = wsd_pkg::PH_HDR0;
		end else begin
			remaining = plen;
			ph = wsd_pkg::PH_DATA;
		end
	endtask

	task automatic length_done(output bit got, output wsd_pkg::ev_item_t res);
		got = 1'b0;
		res = NO_EV;
		if (cur_masked) begin
			hdr_cnt = 2'd0;
			ph = wsd_pkg::PH_KEY;
		end else begin
			header_done(got, res);
		end
	endtask

	// Advances the mirrored parser by one byte; at most one result comes out.
	task automatic deframe(input wsd_pkg::rx_item_t it, output bit got,
			output wsd_pkg::ev_item_t res);
		logic [6:0]  code;
		logic [31:0] kb;
		got = 1'b0;
		res = NO_EV;
		if (it.buf_start && (ph == wsd_pkg::PH_HDR1 || ph == wsd_pkg::PH_EXT ||
				ph == wsd_pkg::PH_KEY)) begin
			res = make_ev(wsd_pkg::EV_INVALID, 16'd0, 8'h00, 1'b0);
			got = 1'b1;
			ph = wsd_pkg::PH_HDR0;
		end
		if (it.buf_start && ph == wsd_pkg::PH_DROP)
			ph = wsd_pkg::PH_HDR0;
		case (ph)
			wsd_pkg::PH_HDR0: begin
				cur_fin    = it.in_byte[7];
				cur_op     = it.in_byte[3:0];
				cur_masked = 1'b0;
				plen       = 16'd0;
				remaining  = 16'd0;
				key        = 32'd0;
				key_idx    = 2'd0;
				hdr_cnt    = 2'd0;
				ph         = wsd_pkg::PH_HDR1;
			end
			wsd_pkg::PH_HDR1: begin
				cur_masked = it.in_byte[7];
				code = it.in_byte[6:0];
				if (cur_op > wsd_pkg::OPCODE_MAX || code == wsd_pkg::LEN_CODE64) begin
					res = make_ev(wsd_pkg::EV_INVALID, 16'd0, 8'h00, 1'b0);
					got = 1'b1;
					ph = wsd_pkg::PH_DROP;
				end else if (code == wsd_pkg::LEN_CODE16) begin
					hdr_cnt = 2'd0;
					ph = wsd_pkg::PH_EXT;
				end else begin
					plen = {9'd0, code};
					length_done(got, res);
				end
			end
			wsd_pkg::PH_EXT: begin
				plen = {plen[7:0], it.in_byte};
				if (hdr_cnt == wsd_pkg::EXT_LAST) begin
					hdr_cnt = 2'd0;
					length_done(got, res);
				end else begin
					hdr_cnt = hdr_cnt + 2'd1;
				end
			end
			wsd_pkg::PH_KEY: begin
				key = {key[23:0], it.in_byte};
				if (hdr_cnt == wsd_pkg::KEY_LAST) begin
					hdr_cnt = 2'd0;
					header_done(got, res);
				end else begin
					hdr_cnt = hdr_cnt + 2'd1;
				end
			end
			wsd_pkg::PH_DATA: begin
				kb = key >> {2'd3 - key_idx, 3'b000};
				res = make_ev(wsd_pkg::EV_PAYLOAD, plen, it.in_byte ^ kb[7:0],
					remaining == 16'd1);
				got = 1'b1;
				key_idx = key_idx + 2'd1;
				remaining = remaining - 16'd1;
				if (remaining == 16'd0)
					ph = wsd_pkg::PH_HDR0;
			end
			default: ;
		endcase
	endtask

	// Results are checked before the byte of the same edge is predicted; latency keeps them apart.
	always @(posedge clk) begin
		wsd_pkg::ev_item_t want;
		wsd_pkg::ev_item_t pred;
		bit                got_one;
		if (arst_n) begin
			if (ev_valid && !ev_stall) begin
				if (pending_events.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: %p", ev_item));
				end else begin
					want = pending_events.pop_front();
					check_field("event_res", ev_item.event_res, want.event_res);
					check_field("opcode", ev_item.opcode, want.opcode);
					check_field("fin", ev_item.fin, want.fin);
					check_field("masked", ev_item.masked, want.masked);
					check_field("frame_size", ev_item.frame_size, want.frame_size);
					check_field("payload_byte", ev_item.payload_byte, want.payload_byte);
					check_field("last", ev_item.last, want.last);
					case (want.event_res)
						wsd_pkg::EV_HEADER:  n_headers++;
						wsd_pkg::EV_INVALID: n_invalid++;
						default:             n_payload++;
					endcase
				end
			end
			if (rx_valid && !rx_stall) begin
				deframe(rx_item, got_one, pred);
				if (row_kind == ROW_TYPED)
					pending_events = {pending_events, row_typed};
				else if (row_kind == ROW_PREDICT && got_one)
					pending_events = {pending_events, pred};
			end
		end
	end

	// Receiver: random stall patterns, plus long hold-offs on request from the sender.
	initial begin
		int hold_left;
		int mode;
		int mode_left;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		ev_stall = 1'b0;
		while (!arst_n) @(negedge clk);
		forever begin
			@(negedge clk);
			if (hold_left == 0 && holds_done < hold_req) begin
				holds_done++;
				hold_left = 90;
			end
			if (hold_left > 0) begin
				hold_left--;
				ev_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 150);
				end
				mode_left--;
				case (mode)
					0: ev_stall <= 1'b0;
					1: ev_stall <= ($urandom_range(0, 3) == 0);
					2: ev_stall <= ($urandom_range(0, 3) != 0);
					default: ev_stall <= ~ev_stall;
				endcase
			end
		end
	end

	// Offers one byte, idling first when the current burst has run out, and waits for acceptance.
	task automatic send_byte(input logic [7:0] b, input logic bs, input row_kind_t k,
			input wsd_pkg::ev_item_t typed);
		int gap;
		if (burst_left == 0 && nogap_left == 0) begin
			gap = $urandom_range(1, 6);
			rx_valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		if (nogap_left > 0)
			nogap_left--;
		rx_valid  <= 1'b1;
		rx_item   <= '{in_byte: b, buf_start: bs};
		row_kind  <= k;
		row_typed <= typed;
		bytes_sent++;
		do @(posedge clk); while (rx_stall);
		@(negedge clk);
	endtask

	// One random unit: mostly well-formed frames, some bad or cut-short headers and noise.
	task automatic send_unit();
		logic [7:0]  hdr [$];
		logic [15:0] len;
		logic [3:0]  op;
		logic        msk;
		logic        lead_bs;
		int          r;
		int          cut;
		op = 4'($urandom_range(0, 10));
		msk = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < 60)
			len = 16'($urandom_range(0, 20));
		else if (r < 75)
			len = 16'($urandom_range(21, 125));
		else if (r < 95)
			len = 16'($urandom_range(0, 300));
		else
			len = 16'($urandom_range(256, 700));
		lead_bs = resync ? 1'b1 : ($urandom_range(0, 2) == 0);
		r = $urandom_range(0, 99);
		if (r >= 95) begin
			// Noise can leave the parser anywhere; the next frame starts a new buffer.
			repeat ($urandom_range(1, 3))
				send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					ROW_PREDICT, NO_EV);
			resync = 1'b1;
			return;
		end
		if (r >= 87) begin
			if ($urandom_range(0, 1)) begin
				send_byte({4'($urandom_range(0, 15)), 4'($urandom_range(11, 15))}, lead_bs,
					ROW_PREDICT, NO_EV);
				send_byte(8'($urandom_range(0, 255)), 1'b0, ROW_PREDICT, NO_EV);
			end else begin
				send_byte({4'($urandom_range(0, 15)), op}, lead_bs, ROW_PREDICT, NO_EV);
				send_byte({msk, wsd_pkg::LEN_CODE64}, 1'b0, ROW_PREDICT, NO_EV);
			end
			repeat ($urandom_range(0, 4))
				send_byte(8'($urandom_range(0, 255)), 1'b0, ROW_PREDICT, NO_EV);
			resync = 1'b1;
			return;
		end
		hdr = {hdr, {4'($urandom_range(0, 15)), op}};
		if (len < 16'd126 && $urandom_range(0, 7) != 0) begin
			hdr = {hdr, {msk, len[6:0]}};
		end else begin
			hdr = {hdr, {msk, wsd_pkg::LEN_CODE16}};
			hdr = {hdr, len[15:8]};
			hdr = {hdr, len[7:0]};
		end
		if (msk)
			repeat (4) hdr = {hdr, 8'($urandom_range(0, 255))};
		if (r >= 78) begin
			// Header cut short by the end of the buffer.
			cut = $urandom_range(1, hdr.size() - 1);
			for (int i = 0; i < cut; i++)
				send_byte(hdr[i], (i == 0) ? lead_bs : 1'b0, ROW_PREDICT, NO_EV);
			resync = 1'b1;
			return;
		end
		foreach (hdr[i])
			send_byte(hdr[i], (i == 0) ? lead_bs : 1'b0, ROW_PREDICT, NO_EV);
		// Buffer starts inside the payload are ignored by the parser.
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 29) == 0),
				ROW_PREDICT, NO_EV);
		resync = 1'b0;
	endtask

	initial begin
		int stage;
		rx_valid   = 1'b0;
		rx_item    = '0;
		row_kind   = ROW_PREDICT;
		row_typed  = NO_EV;
		arst_n     = 1'b0;
		bytes_sent = 0;
		burst_left = 0;
		nogap_left = 0;
		hold_req   = 0;
		resync     = 1'b0;
		stage      = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_byte(DIR_TAB[i].b, DIR_TAB[i].bs, DIR_TAB[i].kind, DIR_TAB[i].res);

		while (bytes_sent < DIR_ROWS + 1150) begin
			if (stage == 0 && bytes_sent >= 300 || stage == 2 && bytes_sent >= 900) begin
				// The receiver holds off while bytes keep coming back to back.
				hold_req++;
				nogap_left = 80;
				stage++;
			end else if (stage == 1 && bytes_sent >= 650) begin
				rx_valid <= 1'b0;
				while (pending_events.size() != 0) @(negedge clk);
				repeat (4) @(negedge clk);
				burst_left = 1;
				stage++;
			end
			send_unit();
		end

		rx_valid <= 1'b0;
		for (int i = 0; i < 5000 && pending_events.size() != 0; i++)
			@(negedge clk);
		repeat (16) @(negedge clk);
		if (pending_events.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_events.size()));
		$display("Sent %0d stream bytes; checked %0d headers, %0d payload bytes,",
			bytes_sent, n_headers, n_payload);
		$display("%0d invalid headers; receiver hold-offs: %0d; mismatches: %0d.",
			n_invalid, holds_done, err_count);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
